>>> hw/rtl/nir_pkg.sv
// nir_pkg: shared types and codes for the NEC infrared frame decoder.
// Used by nir_cfg_regs, nir_decode_core and nec_ir_frame_decoder_unit.
package nir_pkg;

  // Item kinds carried on the input tuser
  localparam logic [1:0] MODE_EDGE    = 2'd0;
  localparam logic [1:0] MODE_TIMEOUT = 2'd1;
  localparam logic [1:0] MODE_REARM   = 2'd2;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_LMARK_MIN  = 3'd0;
  localparam logic [2:0] REG_LMARK_MAX  = 3'd1;
  localparam logic [2:0] REG_LSPACE_MIN = 3'd2;
  localparam logic [2:0] REG_LSPACE_MAX = 3'd3;
  localparam logic [2:0] REG_SHORT_MIN  = 3'd4;
  localparam logic [2:0] REG_SHORT_MAX  = 3'd5;
  localparam logic [2:0] REG_LONG_MIN   = 3'd6;
  localparam logic [2:0] REG_LONG_MAX   = 3'd7;

  // Decoder phases
  typedef enum logic [4:0] {
    PH_LMARK  = 5'b00001,
    PH_LSPACE = 5'b00010,
    PH_MARK   = 5'b00100,
    PH_SPACE  = 5'b01000,
    PH_LAST   = 5'b10000
  } phase_t;

  // Timing windows in ticks
  typedef struct packed {
    logic [15:0] leader_mark_min;
    logic [15:0] leader_mark_max;
    logic [15:0] leader_space_min;
    logic [15:0] leader_space_max;
    logic [15:0] short_min;
    logic [15:0] short_max;
    logic [15:0] long_min;
    logic [15:0] long_max;
  } cfg_regs_t;

  // One result word
  typedef struct packed {
    logic        frame_valid;
    logic        extended;
    logic [15:0] address;
    logic [7:0]  command;
    logic        rejected;
  } result_t;

endpackage

>>> hw/rtl/nir_cfg_regs.sv
// nir_cfg_regs: the eight timing window registers with their reset values.
// Depends on nir_pkg.
module nir_cfg_regs (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  logic [2:0]          wr_index,
  input  logic [15:0]         wr_data,
  output nir_pkg::cfg_regs_t  regs
);
  import nir_pkg::*;

  cfg_regs_t regs_r;

  // Register writes, one word per handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.leader_mark_min  <= 16'd120;
      regs_r.leader_mark_max  <= 16'd160;
      regs_r.leader_space_min <= 16'd60;
      regs_r.leader_space_max <= 16'd80;
      regs_r.short_min        <= 16'd5;
      regs_r.short_max        <= 16'd14;
      regs_r.long_min         <= 16'd20;
      regs_r.long_max         <= 16'd32;
    end else if (wr_en) begin
      case (wr_index)
        REG_LMARK_MIN:  regs_r.leader_mark_min  <= wr_data;
        REG_LMARK_MAX:  regs_r.leader_mark_max  <= wr_data;
        REG_LSPACE_MIN: regs_r.leader_space_min <= wr_data;
        REG_LSPACE_MAX: regs_r.leader_space_max <= wr_data;
        REG_SHORT_MIN:  regs_r.short_min        <= wr_data;
        REG_SHORT_MAX:  regs_r.short_max        <= wr_data;
        REG_LONG_MIN:   regs_r.long_min         <= wr_data;
        REG_LONG_MAX:   regs_r.long_max         <= wr_data;
        default:        regs_r <= regs_r;
      endcase
    end
  end

  assign regs = regs_r;

endmodule

>>> hw/rtl/nir_decode_core.sv
// nir_decode_core: frame state and the combinational decode of a registered item.
// Depends on nir_pkg; the result is registered by the caller.
module nir_decode_core #(
  parameter int unsigned END_GAP = 40
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [1:0]          mode,
  input  logic [31:0]         stamp,
  input  nir_pkg::cfg_regs_t  regs,
  output nir_pkg::result_t    result
);
  import nir_pkg::*;

  logic        await_first_r, await_first_nxt;
  logic [31:0] prev_stamp_r,  prev_stamp_nxt;
  phase_t      phase_r,       phase_nxt;
  logic        bad_frame_r,   bad_frame_nxt;
  logic [5:0]  bit_count_r,   bit_count_nxt;
  logic [31:0] shift_word_r,  shift_word_nxt;

  logic [31:0] diff_fwd, diff_rev, iv;
  logic        report;
  logic [7:0]  lo_byte, hi_byte;

  // Interval: both differences in parallel, pick by sign of the forward one
  assign diff_fwd = stamp - prev_stamp_r;
  assign diff_rev = prev_stamp_r - stamp;
  assign iv       = diff_fwd[31] ? diff_rev : diff_fwd;

  // Window compares against 16-bit limits
  function automatic logic below(input logic [31:0] v, input logic [15:0] lim);
    below = (v[31:16] == 16'd0) && (v[15:0] < lim);
  endfunction

  function automatic logic above(input logic [31:0] v, input logic [15:0] lim);
    above = (v[31:16] != 16'd0) || (v[15:0] > lim);
  endfunction

  // Next state
  always_comb begin
    await_first_nxt = await_first_r;
    prev_stamp_nxt  = prev_stamp_r;
    phase_nxt       = phase_r;
    bad_frame_nxt   = bad_frame_r;
    bit_count_nxt   = bit_count_r;
    shift_word_nxt  = shift_word_r;
    report          = 1'b0;
    case (mode)
      MODE_EDGE: begin
        prev_stamp_nxt = stamp;
        if (await_first_r) begin
          await_first_nxt = 1'b0;
          phase_nxt       = PH_LMARK;
          bad_frame_nxt   = 1'b0;
          bit_count_nxt   = 6'd0;
          shift_word_nxt  = 32'd0;
        end else if (!bad_frame_r) begin
          case (phase_r)
            PH_LAST: begin
              if (iv > 32'(END_GAP)) report = 1'b1;
              else bad_frame_nxt = 1'b1;
            end
            PH_LMARK: begin
              if (below(iv, regs.leader_mark_min) || above(iv, regs.leader_mark_max))
                bad_frame_nxt = 1'b1;
              else
                phase_nxt = PH_LSPACE;
            end
            PH_LSPACE: begin
              if (below(iv, regs.leader_space_min) || above(iv, regs.leader_space_max))
                bad_frame_nxt = 1'b1;
              else
                phase_nxt = PH_MARK;
            end
            PH_MARK: begin
              if (below(iv, regs.short_min) || above(iv, regs.short_max))
                bad_frame_nxt = 1'b1;
              else
                phase_nxt = bit_count_r[5] ? PH_LAST : PH_SPACE;
            end
            PH_SPACE: begin
              // too-short space keeps the phase; too-long still moves on
              if (below(iv, regs.short_min)) begin
                bad_frame_nxt = 1'b1;
              end else begin
                phase_nxt = PH_MARK;
                if (above(iv, regs.long_max)) begin
                  bad_frame_nxt = 1'b1;
                end else begin
                  shift_word_nxt = {!below(iv, regs.long_min), shift_word_r[31:1]};
                  bit_count_nxt  = bit_count_r + 6'd1;
                end
              end
            end
            default: phase_nxt = phase_r;
          endcase
        end
      end
      MODE_TIMEOUT: begin
        report          = !await_first_r && !bad_frame_r && (phase_r == PH_LAST);
        await_first_nxt = 1'b1;
      end
      MODE_REARM: begin
        await_first_nxt = 1'b1;
        phase_nxt       = PH_LMARK;
        bad_frame_nxt   = 1'b0;
        bit_count_nxt   = 6'd0;
        shift_word_nxt  = 32'd0;
      end
      default: report = 1'b0;
    endcase
  end

  // Frame report fields
  assign lo_byte = shift_word_r[7:0];
  assign hi_byte = shift_word_r[15:8];

  always_comb begin
    result             = '0;
    result.rejected    = bad_frame_nxt;
    if (report) begin
      result.frame_valid = 1'b1;
      result.extended    = (lo_byte != ~hi_byte);
      result.address     = result.extended ? shift_word_r[15:0] : {8'd0, lo_byte};
      result.command     = shift_word_r[31:24];
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      await_first_r <= 1'b1;
      prev_stamp_r  <= 32'd0;
      phase_r       <= PH_LMARK;
      bad_frame_r   <= 1'b0;
      bit_count_r   <= 6'd0;
      shift_word_r  <= 32'd0;
    end else if (step) begin
      await_first_r <= await_first_nxt;
      prev_stamp_r  <= prev_stamp_nxt;
      phase_r       <= phase_nxt;
      bad_frame_r   <= bad_frame_nxt;
      bit_count_r   <= bit_count_nxt;
      shift_word_r  <= shift_word_nxt;
    end
  end

endmodule

>>> hw/rtl/nec_ir_frame_decoder_unit.sv
// nec_ir_frame_decoder_unit: top level of the NEC infrared frame decoder.
// Depends on nir_pkg, nir_cfg_regs and nir_decode_core.
//
// Decodes NEC pulse-distance frames from timestamped edges, one result word
// per input word. An input word is captured in an input register, decoded
// combinationally against the frame state and written to the output register,
// so the block sustains one word per clock while results are taken; out_tvalid
// rises once the word has passed both registers. The input register frees up
// whenever the output register is empty or being taken; a stalled result lets
// one more word into the input register, after which in_tready drops until the
// result is taken. Configuration writes are always ready and take effect on the
// next cycle; write them only while the decoder is idle.
module nec_ir_frame_decoder_unit #(
  parameter int unsigned END_GAP = 40
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] stamp
  input  logic [1:0]  in_tuser,   // [1:0] mode
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [0] extended, [16:1] address, [24:17] command,
                                  // [25] rejected, [31:26] zero
  output logic [0:0]  out_tuser,  // [0] frame_valid
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import nir_pkg::*;

  logic        in_valid_r;
  logic [1:0]  mode_r;
  logic [31:0] stamp_r;
  logic        out_valid_r;
  result_t     res_r;
  result_t     res_comb;
  cfg_regs_t   regs;
  logic        advance;

  // Configuration registers
  assign cfg_ready = 1'b1;

  nir_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .regs     (regs)
  );

  // Pipeline control
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      mode_r  <= in_tuser;
      stamp_r <= in_tdata;
    end
  end

  // Decode step
  nir_decode_core #(
    .END_GAP (END_GAP)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .mode   (mode_r),
    .stamp  (stamp_r),
    .regs   (regs),
    .result (res_comb)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) res_r <= res_comb;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, res_r.rejected, res_r.command, res_r.address, res_r.extended};
  assign out_tuser  = res_r.frame_valid;

  // A reported frame is never one that is marked bad
  a_valid_not_rejected: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> !out_tdata[25])
    else $error("frame reported while rejected");

  // Frame fields are zero when no frame is reported
  a_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> (out_tdata[24:0] == 25'd0))
    else $error("frame fields set without a frame");

  // An empty output register never blocks intake
  a_intake_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

endmodule

>>> dv/nec_ir_frame_decoder_unit_tb.sv
// nec_ir_frame_decoder_unit_tb: self-checking bench for the NEC infrared frame decoder.
// Needs nir_pkg and the nec_ir_frame_decoder_unit RTL; a built-in frame predictor, or
// a directed row's expected word, scores every result for edge, timeout and rearm items.
module nec_ir_frame_decoder_unit_tb;
  import nir_pkg::*;

  localparam int unsigned END_GAP      = 40;
  localparam int          LIMIT_CYCLES = 200000;
  localparam logic [1:0]  MODE_UNUSED  = 2'd3;

  localparam cfg_regs_t WIN_RESET = '{16'd120, 16'd160, 16'd60, 16'd80,
                                      16'd5, 16'd14, 16'd20, 16'd32};
  localparam result_t RES_NONE     = '0;
  localparam result_t RES_REJECTED = '{1'b0, 1'b0, 16'h0, 8'h0, 1'b1};

  // Directed row: val is an absolute stamp, or a gap from the last stamp when rel is set
  typedef struct packed {
    logic [1:0]  mode;
    logic        rel;
    logic [31:0] val;
    logic        chk;
    result_t     exp;
  } dir_row_t;

  localparam dir_row_t DIRECTED_ROWS [25] = '{
    '{MODE_TIMEOUT, 1'b0, 32'h0000_0000, 1'b1, RES_NONE},     // timeout while armed
    '{MODE_UNUSED,  1'b0, 32'hffff_ffff, 1'b1, RES_NONE},     // unused mode ignored
    '{MODE_EDGE,    1'b0, 32'h0000_0000, 1'b1, RES_NONE},     // first edge restarts
    '{MODE_EDGE,    1'b0, 32'hffff_ffff, 1'b1, RES_REJECTED}, // wrapped gap of 1
    '{MODE_EDGE,    1'b0, 32'h7fff_ffff, 1'b1, RES_REJECTED}, // rejected: stamp only
    '{MODE_UNUSED,  1'b0, 32'h0000_0000, 1'b1, RES_REJECTED}, // unused keeps flag
    '{MODE_REARM,   1'b0, 32'h0000_0000, 1'b1, RES_NONE},
    '{MODE_EDGE,    1'b0, 32'h7fff_ffff, 1'b1, RES_NONE},
    '{MODE_EDGE,    1'b1, 32'd120,       1'b0, RES_NONE},     // leader mark at min
    '{MODE_EDGE,    1'b1, 32'd60,        1'b0, RES_NONE},     // leader space at min
    '{MODE_EDGE,    1'b1, 32'd5,         1'b0, RES_NONE},     // shortest mark
    '{MODE_EDGE,    1'b1, 32'd32,        1'b0, RES_NONE},     // longest space, one
    '{MODE_EDGE,    1'b1, 32'd14,        1'b0, RES_NONE},     // longest mark
    '{MODE_EDGE,    1'b1, 32'd20,        1'b0, RES_NONE},     // one at threshold
    '{MODE_EDGE,    1'b1, 32'd5,         1'b0, RES_NONE},
    '{MODE_EDGE,    1'b1, 32'd19,        1'b0, RES_NONE},     // zero just below it
    '{MODE_EDGE,    1'b1, 32'd5,         1'b0, RES_NONE},
    '{MODE_EDGE,    1'b1, 32'd4,         1'b1, RES_REJECTED}, // space too short
    '{MODE_TIMEOUT, 1'b0, 32'h0000_0000, 1'b1, RES_REJECTED}, // partial frame dropped
    '{MODE_EDGE,    1'b0, 32'h0000_1000, 1'b1, RES_NONE},     // restart clears flag
    '{MODE_EDGE,    1'b1, 32'd161,       1'b1, RES_REJECTED}, // leader mark too long
    '{MODE_REARM,   1'b0, 32'h0000_0000, 1'b1, RES_NONE},
    '{MODE_EDGE,    1'b0, 32'h8000_0000, 1'b1, RES_NONE},
    '{MODE_EDGE,    1'b0, 32'h0000_0000, 1'b1, RES_REJECTED}, // gap of exactly 2^31
    '{MODE_REARM,   1'b0, 32'hffff_ffff, 1'b1, RES_NONE}
  };

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;
  logic [1:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [0:0]  out_tuser;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index  = '0;
  logic [15:0] cfg_data   = '0;

  logic        hold_rx    = 1'b0;
  int unsigned snd_idle_pct  = 0;
  int unsigned rcv_stall_pct = 0;
  int          mismatch_count = 0;
  int          results_seen   = 0;
  int          items_sent     = 0;
  int          cycle_count    = 0;
  result_t     pending_results[$];

  // Predicted decoder state
  logic        armed;
  logic [31:0] last_stamp;
  phase_t      ph;
  logic        bad;
  logic [5:0]  nbits;
  logic [31:0] rx_word;
  cfg_regs_t   win;

  nec_ir_frame_decoder_unit #(
    .END_GAP(END_GAP)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // ---------------------------------------------------------------- predictor
  function automatic void clear_frame();
    ph      = PH_LMARK;
    bad     = 1'b0;
    nbits   = '0;
    rx_word = '0;
  endfunction

  function automatic result_t frame_report();
    result_t r;
    r = '0;
    r.frame_valid = 1'b1;
    r.command     = rx_word[31:24];
    if (rx_word[7:0] == ~rx_word[15:8]) begin
      r.address = {8'h00, rx_word[7:0]};
    end else begin
      r.extended = 1'b1;
      r.address  = rx_word[15:0];
    end
    return r;
  endfunction

  function automatic void decode_interval(input logic [31:0] iv, inout result_t r);
    if (bad) return;
    case (ph)
      PH_LAST: begin
        if (iv > END_GAP) r = frame_report();
        else bad = 1'b1;
      end
      PH_LMARK: begin
        if (iv < win.leader_mark_min || iv > win.leader_mark_max) bad = 1'b1;
        else ph = PH_LSPACE;
      end
      PH_LSPACE: begin
        if (iv < win.leader_space_min || iv > win.leader_space_max) bad = 1'b1;
        else ph = PH_MARK;
      end
      PH_MARK: begin
        if (iv < win.short_min || iv > win.short_max) bad = 1'b1;
        else ph = (nbits >= 6'd32) ? PH_LAST : PH_SPACE;
      end
      default: begin
        // bit space: long enough means a one, shifted in at the top
        if (iv < win.short_min) begin
          bad = 1'b1;
        end else begin
          ph = PH_MARK;
          if (iv > win.long_max) begin
            bad = 1'b1;
          end else begin
            rx_word = {iv >= win.long_min, rx_word[31:1]};
            nbits   = nbits + 6'd1;
          end
        end
      end
    endcase
  endfunction

  function automatic result_t decode_ir_word(input logic [1:0] mode, input logic [31:0] stamp);
    result_t     r;
    logic [31:0] d;
    r = '0;
    case (mode)
      MODE_EDGE: begin
        d = stamp - last_stamp;
        if (d[31]) d = 32'd0 - d;
        last_stamp = stamp;
        if (armed) begin
          clear_frame();
          armed = 1'b0;
        end else begin
          decode_interval(d, r);
        end
      end
      MODE_TIMEOUT: begin
        if (!armed && !bad && ph == PH_LAST) r = frame_report();
        armed = 1'b1;
      end
      MODE_REARM: begin
        armed = 1'b1;
        clear_frame();
      end
      default: ;
    endcase
    r.rejected = bad;
    return r;
  endfunction

  // ---------------------------------------------------------------- configuration
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_LMARK_MIN:  win.leader_mark_min  = val;
      REG_LMARK_MAX:  win.leader_mark_max  = val;
      REG_LSPACE_MIN: win.leader_space_min = val;
      REG_LSPACE_MAX: win.leader_space_max = val;
      REG_SHORT_MIN:  win.short_min        = val;
      REG_SHORT_MAX:  win.short_max        = val;
      REG_LONG_MIN:   win.long_min         = val;
      default:        win.long_max         = val;
    endcase
    @(posedge clk);
  endtask

  task automatic load_windows(input cfg_regs_t w);
    write_reg(REG_LMARK_MIN,  w.leader_mark_min);
    write_reg(REG_LMARK_MAX,  w.leader_mark_max);
    write_reg(REG_LSPACE_MIN, w.leader_space_min);
    write_reg(REG_LSPACE_MAX, w.leader_space_max);
    write_reg(REG_SHORT_MIN,  w.short_min);
    write_reg(REG_SHORT_MAX,  w.short_max);
    write_reg(REG_LONG_MIN,   w.long_min);
    write_reg(REG_LONG_MAX,   w.long_max);
  endtask

  // Ordered windows, so well-formed frames can get through
  function automatic cfg_regs_t rand_windows();
    cfg_regs_t w;
    w.leader_mark_min  = 16'($urandom_range(400, 0));
    w.leader_mark_max  = 16'(w.leader_mark_min + $urandom_range(200, 0));
    w.leader_space_min = 16'($urandom_range(300, 0));
    w.leader_space_max = 16'(w.leader_space_min + $urandom_range(100, 0));
    w.short_min        = 16'($urandom_range(20, 0));
    w.short_max        = 16'(w.short_min + $urandom_range(30, 0));
    w.long_min         = 16'(w.short_min + $urandom_range(40, 1));
    w.long_max         = 16'(w.long_min + $urandom_range(40, 0));
    return w;
  endfunction

  // ---------------------------------------------------------------- input side
  task automatic send_word(input logic [1:0] mode, input logic [31:0] stamp,
                           input logic typed, input result_t typed_res);
    result_t r;
    while ($urandom_range(99, 0) < snd_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= stamp;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    r = decode_ir_word(mode, stamp);
    pending_results.push_back(typed ? typed_res : r);
    if (mode != MODE_UNUSED) items_sent++;
  endtask

  task automatic send_item(input logic [1:0] mode, input logic [31:0] stamp);
    send_word(mode, stamp, 1'b0, RES_NONE);
  endtask

  // Edge a given gap away; direction is random since only the magnitude counts
  task automatic send_gap(input logic [31:0] iv);
    logic [31:0] s;
    s = $urandom_range(1, 0) ? last_stamp + iv : last_stamp - iv;
    send_item(MODE_EDGE, s);
  endtask

  function automatic int pick_in(input int lo, input int hi);
    int r;
    if (hi <= lo) return lo;
    r = $urandom_range(3, 0);
    if (r == 0) return lo;
    if (r == 1) return hi;
    return $urandom_range(hi, lo);
  endfunction

  function automatic int pick_out(input int lo, input int hi);
    if (lo > 0 && $urandom_range(1, 0)) return lo - 1;
    return hi + 1 + $urandom_range(15, 0);
  endfunction

  // One frame: arm, restart edge, leader, 32 bits, final mark, then an ending.
  // A quarter of frames break at a random point.
  task automatic send_frame();
    logic [31:0] data;
    int          brk, lo, hi, lo0, hi0, lo1, hi1;
    data = $urandom;
    if ($urandom_range(1, 0)) data[15:8] = ~data[7:0];
    brk = ($urandom_range(99, 0) < 25) ? $urandom_range(66, 0) : -1;
    send_item($urandom_range(1, 0) ? MODE_REARM : MODE_TIMEOUT, $urandom);
    send_item(MODE_EDGE, $urandom);
    for (int k = 0; k <= 66; k++) begin
      if (k == 0) begin
        lo = int'(win.leader_mark_min);
        hi = int'(win.leader_mark_max);
      end else if (k == 1) begin
        lo = int'(win.leader_space_min);
        hi = int'(win.leader_space_max);
      end else if (k % 2 == 0) begin
        lo = int'(win.short_min);
        hi = int'(win.short_max);
      end else begin
        lo1 = (win.long_min > win.short_min) ? int'(win.long_min) : int'(win.short_min);
        hi1 = int'(win.long_max);
        lo0 = int'(win.short_min);
        hi0 = (int'(win.long_min) - 1 < int'(win.long_max)) ?
              int'(win.long_min) - 1 : int'(win.long_max);
        // fall back to the other bit value when a window is empty
        if ((data[(k - 3) / 2] && hi1 >= lo1) || hi0 < lo0) begin
          lo = lo1;
          hi = hi1;
        end else begin
          lo = lo0;
          hi = hi0;
        end
      end
      if (k == brk) begin
        if ($urandom_range(2, 0) == 0)
          send_item($urandom_range(1, 0) ? MODE_REARM : MODE_TIMEOUT, $urandom);
        else
          send_gap(32'(pick_out(lo, hi)));
        return;
      end
      send_gap(32'(pick_in(lo, hi)));
    end
    case ($urandom_range(2, 0))
      0: send_item(MODE_TIMEOUT, $urandom);
      1: begin
        send_gap(END_GAP + 1 + (($urandom_range(3, 0) == 0) ? 0 : $urandom_range(5000, 0)));
        // another edge: long gap repeats the frame, short one rejects it
        if ($urandom_range(1, 0))
          send_gap($urandom_range(1, 0) ? $urandom_range(END_GAP, 0) :
                   END_GAP + 1 + $urandom_range(300, 0));
      end
      default: begin
        send_gap(END_GAP);
        send_item(MODE_TIMEOUT, $urandom);
      end
    endcase
  endtask

  task automatic send_noise();
    int         n;
    logic [1:0] m;
    n = $urandom_range(6, 1);
    repeat (n) begin
      m = 2'($urandom_range(3, 0));
      if (m == MODE_EDGE && $urandom_range(1, 0)) send_gap($urandom_range(200, 0));
      else send_item(m, $urandom);
    end
  endtask

  task automatic run_traffic(input int count);
    int stop;
    stop = items_sent + count;
    while (items_sent < stop) begin
      if ($urandom_range(3, 0) != 0) send_frame();
      else send_noise();
    end
  endtask

  // Wait until every expected word is back, then let the pipeline settle
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- output side
  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    mismatch_count++;
    $display("mismatch on %s at result word %0d: got %h, want %h",
             what, results_seen, got, want);
  endtask

  task automatic check_result();
    result_t got, want;
    got = {out_tuser[0], out_tdata[0], out_tdata[16:1], out_tdata[24:17], out_tdata[25]};
    results_seen++;
    if (pending_results.size() == 0) begin
      flag_mismatch("unexpected word", 32'(got), '0);
      return;
    end
    want = pending_results.pop_front();
    if (got.frame_valid != want.frame_valid)
      flag_mismatch("frame_valid", 32'(got.frame_valid), 32'(want.frame_valid));
    if (got.extended != want.extended)
      flag_mismatch("extended", 32'(got.extended), 32'(want.extended));
    if (got.address != want.address)
      flag_mismatch("address", 32'(got.address), 32'(want.address));
    if (got.command != want.command)
      flag_mismatch("command", 32'(got.command), 32'(want.command));
    if (got.rejected != want.rejected)
      flag_mismatch("rejected", 32'(got.rejected), 32'(want.rejected));
    if (out_tdata[31:26] != '0)
      flag_mismatch("padding", 32'(out_tdata[31:26]), '0);
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) check_result();
      out_tready <= !hold_rx && ($urandom_range(99, 0) >= rcv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin
    win        = WIN_RESET;
    armed      = 1'b1;
    last_stamp = '0;
    clear_frame();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED_ROWS[i])
      send_word(DIRECTED_ROWS[i].mode,
                DIRECTED_ROWS[i].rel ? last_stamp + DIRECTED_ROWS[i].val
                                     : DIRECTED_ROWS[i].val,
                DIRECTED_ROWS[i].chk, DIRECTED_ROWS[i].exp);
    settle();

    for (int p = 0; p < 6; p++) begin
      case (p % 4)
        0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
        1: begin snd_idle_pct = 60; rcv_stall_pct = 0;  end
        2: begin snd_idle_pct = 0;  rcv_stall_pct = 60; end
        default: begin snd_idle_pct = 24; rcv_stall_pct = 24; end
      endcase
      case (p)
        0: ;
        2: load_windows('0);
        3: load_windows('1);
        5: load_windows(WIN_RESET);
        default: load_windows(rand_windows());
      endcase
      if (p == 0) begin
        // long receiver hold while words keep coming, so intake backs up
        fork
          begin
            hold_rx <= 1'b1;
            repeat (300) @(posedge clk);
            hold_rx <= 1'b0;
          end
          run_traffic(90);
        join
      end else begin
        run_traffic(90);
      end
      settle();
    end

    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/nir_pkg.sv
hw/rtl/nir_cfg_regs.sv
hw/rtl/nir_decode_core.sv
hw/rtl/nec_ir_frame_decoder_unit.sv
dv/nec_ir_frame_decoder_unit_tb.sv
